@@ hdl/zsn_pkg.sv @@
// Shared constants and types for the z-score row normaliser.
package zsn_pkg;

	localparam int Z_BITS          = 16;
	localparam int FRAC_BITS       = 12;
	localparam int ROOT_BITS       = Z_BITS + 1;
	localparam int RAD_BITS        = 2 * ROOT_BITS;
	localparam int QUO_BITS        = RAD_BITS - 1;
	localparam int DIV_SHIFT       = 2 * FRAC_BITS + 2;
	localparam int PRE_SHIFT       = QUO_BITS - DIV_SHIFT;
	localparam int K_MAX           = 2 ** (Z_BITS - 1);
	localparam int SQRT_MIN_REM    = ROOT_BITS + 3;
	localparam int DEF_MAX_LEN     = 64;
	localparam int DEF_SAMPLE_BITS = 16;

	typedef struct packed {
		logic en;
		logic clr;
	} acc_ctrl_t;

endpackage

@@ hdl/z_score_row_normalizer.sv @@
// Top level: z-score row normaliser with a shared iterative divide/root unit.
// Input words are taken one per cycle while a row is collected, then ST_SETUP1 and ST_SETUP2
// close the row. Each result takes 33 divide steps and 17 root steps in the shared unit,
// stops at the range check if it saturates, skips both if the row is flat or the sample equals
// the mean; a stalled output word holds the sequencer until taken. arst_n clears all control.
module z_score_row_normalizer
	import zsn_pkg::*;
#(
	parameter int MAX_LEN     = DEF_MAX_LEN,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          row_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [Z_BITS-1:0]      zscore,
	output logic                          flat_row,
	output logic                          run_last
);

	localparam int CW    = $clog2(MAX_LEN + 1);
	localparam int AW    = $clog2(MAX_LEN);
	localparam int SW    = SAMPLE_BITS + CW;
	localparam int QW    = 2 * SAMPLE_BITS + CW - 1;
	localparam int MW    = SAMPLE_BITS + CW;
	localparam int PW    = MW + 1;
	localparam int NQW   = QW + CW;
	localparam int DW    = NQW;
	localparam int RW    = (DW + 1 > SQRT_MIN_REM) ? DW + 1 : SQRT_MIN_REM;
	localparam int STEPW = $clog2(QUO_BITS);

	typedef enum logic [3:0] {
		ST_COLLECT,
		ST_SETUP1,
		ST_SETUP2,
		ST_RD,
		ST_MUL,
		ST_NUM,
		ST_SQR,
		ST_CHK,
		ST_DIV,
		ST_SQRT,
		ST_FIN
	} state_t;

	state_t                       state_q;
	logic        [AW-1:0]         idx_q;
	logic        [STEPW-1:0]      step_q;
	logic                         skip_q;
	logic                         sat_q;

	logic        [CW-1:0]         cnt;
	logic signed [SW-1:0]         sum;
	logic        [QW-1:0]         sqsum;
	acc_ctrl_t                    acc_ctrl;
	logic signed [SAMPLE_BITS-1:0] rd_data;

	logic        [NQW-1:0]        nq_q;
	logic        [2*MW-1:0]       sqr_q;
	logic        [DW-1:0]         d_q;
	logic                         flat_q;
	logic signed [PW-1:0]         prod_q;
	logic                         neg_q;
	logic        [MW-1:0]         mag_q;
	logic        [RW-1:0]         rem_q;
	logic        [RAD_BITS-1:0]   quo_q;
	logic        [ROOT_BITS-1:0]  root_q;

	logic                         in_acc;
	logic                         close_c;
	logic                         out_free;
	logic                         last_c;
	logic signed [SW-1:0]         sum_neg;
	logic        [MW-1:0]         s_mag;
	logic        [MW-1:0]         sq_op;
	logic        [2*MW-1:0]       sq_res;
	logic        [NQW-1:0]        nq_c;
	logic                         flat_c;
	logic        [NQW-1:0]        d_c;
	logic signed [PW-1:0]         num_c;
	logic signed [PW-1:0]         num_neg;
	logic        [MW-1:0]         mag_c;
	logic                         num_zero;
	logic        [RW-1:0]         csu_a;
	logic        [RW-1:0]         csu_b;
	logic                         csu_ge;
	logic        [RW-1:0]         csu_diff;
	logic        [ROOT_BITS:0]    kr;
	logic        [ROOT_BITS-1:0]  k_root;
	logic        [ROOT_BITS-1:0]  k_c;
	logic        [ROOT_BITS-1:0]  k_neg;
	logic        [Z_BITS-1:0]     z_c;

	assign in_stall = (state_q != ST_COLLECT);
	assign in_acc   = in_valid && !in_stall;
	assign close_c  = row_end || ((cnt + CW'(1)) == CW'(MAX_LEN));
	assign out_free = !out_valid || !out_stall;
	assign last_c   = (CW'(idx_q) + CW'(1)) == cnt;

	assign acc_ctrl.en  = in_acc;
	assign acc_ctrl.clr = (state_q == ST_FIN) && out_free && last_c;

	zsn_accum #(
		.SB (SAMPLE_BITS),
		.CW (CW),
		.SW (SW),
		.QW (QW)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (acc_ctrl),
		.sample  (sample),
		.cnt_q   (cnt),
		.sum_q   (sum),
		.sqsum_q (sqsum)
	);

	zsn_row_buf #(
		.DEPTH (MAX_LEN),
		.AW    (AW),
		.DW    (SAMPLE_BITS)
	) u_row_buf (
		.clk   (clk),
		.we    (in_acc),
		.waddr (cnt[AW-1:0]),
		.wdata (sample),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	zsn_csu #(
		.W (RW)
	) u_csu (
		.a    (csu_a),
		.b    (csu_b),
		.ge   (csu_ge),
		.diff (csu_diff)
	);

	// row statistics
	assign sum_neg = -sum;
	assign s_mag   = sum[SW-1] ? sum_neg : sum;
	assign sq_op   = (state_q == ST_SETUP1) ? s_mag : mag_q;
	assign sq_res  = (2*MW)'(sq_op) * (2*MW)'(sq_op);
	assign nq_c    = cnt * sqsum;
	assign flat_c  = ({1'b0, nq_q} <= sqr_q);
	assign d_c     = nq_q - sqr_q[NQW-1:0];

	// centred sample
	assign num_c    = prod_q - PW'(sum);
	assign num_neg  = -num_c;
	assign mag_c    = num_c[PW-1] ? num_neg[MW-1:0] : num_c[MW-1:0];
	assign num_zero = (num_c == '0);

	always_comb begin
		csu_a = '0;
		csu_b = RW'(d_q);
		case (state_q)
			ST_CHK: begin
				csu_a = RW'(sqr_q >> PRE_SHIFT);
			end
			ST_DIV: begin
				csu_a = {rem_q[RW-2:0], quo_q[RAD_BITS-1]};
			end
			ST_SQRT: begin
				csu_a = {rem_q[RW-3:0], quo_q[RAD_BITS-1 -: 2]};
				csu_b = {(RW-2)'(root_q), 2'b01};
			end
			default: ;
		endcase
	end

	// round to nearest from the root of the scaled ratio, then clamp
	assign kr     = {1'b0, root_q} + (ROOT_BITS+1)'(1);
	assign k_root = kr[ROOT_BITS:1];

	always_comb begin
		if (skip_q) begin
			k_c = '0;
		end else if (sat_q || (k_root > ROOT_BITS'(K_MAX))) begin
			k_c = ROOT_BITS'(K_MAX);
		end else begin
			k_c = k_root;
		end
	end

	assign k_neg = -k_c;
	assign z_c   = neg_q ? k_neg[Z_BITS-1:0] :
		((k_c >= ROOT_BITS'(K_MAX)) ? Z_BITS'(K_MAX - 1) : k_c[Z_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_COLLECT;
			idx_q     <= '0;
			step_q    <= '0;
			skip_q    <= 1'b0;
			sat_q     <= 1'b0;
			out_valid <= 1'b0;
			zscore    <= '0;
			flat_row  <= 1'b0;
			run_last  <= 1'b0;
		end else begin
			if (out_valid && !out_stall && (state_q != ST_FIN)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_COLLECT: begin
					if (in_acc && close_c) begin
						state_q <= ST_SETUP1;
					end
				end
				ST_SETUP1: begin
					state_q <= ST_SETUP2;
				end
				ST_SETUP2: begin
					idx_q   <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					skip_q  <= flat_q || num_zero;
					sat_q   <= 1'b0;
					state_q <= (flat_q || num_zero) ? ST_FIN : ST_SQR;
				end
				ST_SQR: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (csu_ge) begin
						sat_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						step_q  <= STEPW'(QUO_BITS - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						step_q  <= STEPW'(ROOT_BITS - 1);
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q - STEPW'(1);
					end
				end
				ST_SQRT: begin
					if (step_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q - STEPW'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid <= 1'b1;
						zscore    <= z_c;
						flat_row  <= flat_q;
						run_last  <= last_c;
						if (last_c) begin
							state_q <= ST_COLLECT;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SETUP1: begin
				sqr_q <= sq_res;
				nq_q  <= nq_c;
			end
			ST_SETUP2: begin
				flat_q <= flat_c;
				d_q    <= flat_c ? '0 : d_c;
			end
			ST_MUL: begin
				prod_q <= PW'($signed({1'b0, cnt})) * PW'(rd_data);
			end
			ST_NUM: begin
				neg_q <= num_c[PW-1];
				mag_q <= mag_c;
			end
			ST_SQR: begin
				sqr_q <= sq_res;
			end
			ST_CHK: begin
				rem_q <= RW'(sqr_q >> PRE_SHIFT);
				quo_q <= {sqr_q[PRE_SHIFT-1:0], {(RAD_BITS-PRE_SHIFT){1'b0}}};
			end
			ST_DIV: begin
				rem_q  <= (step_q == '0) ? '0 : (csu_ge ? csu_diff : csu_a);
				quo_q  <= {quo_q[RAD_BITS-2:0], csu_ge};
				root_q <= '0;
			end
			ST_SQRT: begin
				rem_q  <= csu_ge ? csu_diff : csu_a;
				quo_q  <= {quo_q[RAD_BITS-3:0], 2'b00};
				root_q <= {root_q[ROOT_BITS-2:0], csu_ge};
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && flat_row) |-> (zscore == '0))
		else $error("flat row word with non-zero zscore");

	a_row_close: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && row_end) |=> (state_q == ST_SETUP1))
		else $error("row end did not close the row");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < RW'(d_q)))
		else $error("divider remainder not below divisor");
`endif

endmodule

@@ hdl/zsn_csu.sv @@
// Shared compare-and-subtract unit for the divide and square-root steps.
module zsn_csu
	import zsn_pkg::*;
#(
	parameter int W = 20
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);

	logic [W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign ge   = ~full[W];
	assign diff = full[W-1:0];

endmodule

@@ hdl/zsn_row_buf.sv @@
// Row sample store, one write port and one registered read port.
module zsn_row_buf
	import zsn_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_LEN,
	parameter int AW    = 6,
	parameter int DW    = DEF_SAMPLE_BITS
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/zsn_accum.sv @@
// Row statistics: sample count, running sum and running sum of squares.
module zsn_accum
	import zsn_pkg::*;
#(
	parameter int SB = DEF_SAMPLE_BITS,
	parameter int CW = 7,
	parameter int SW = 23,
	parameter int QW = 38
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  acc_ctrl_t            ctrl,
	input  logic signed [SB-1:0] sample,
	output logic        [CW-1:0] cnt_q,
	output logic signed [SW-1:0] sum_q,
	output logic        [QW-1:0] sqsum_q
);

	logic signed [2*SB-1:0] sq;

	assign sq = sample * sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
		end else if (ctrl.clr) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
		end else if (ctrl.en) begin
			cnt_q   <= cnt_q + CW'(1);
			sum_q   <= sum_q + SW'(sample);
			sqsum_q <= sqsum_q + QW'($unsigned(sq));
		end
	end

endmodule
